>>> src/kvpt_pkg.sv
// kvpt_pkg: shared types, character codes and helpers for the key/value tokenizer
// no dependencies; imported by kvpt_core, key_value_param_tokenizer_top and tb
`timescale 1ns / 1ps
`default_nettype none

package kvpt_pkg;

    typedef enum logic [2:0] {
        ST_BEFORE_NAME  = 3'd0,
        ST_IN_NAME      = 3'd1,
        ST_AFTER_NAME   = 3'd2,
        ST_BEFORE_VALUE = 3'd3,
        ST_VAL_DQ       = 3'd4,
        ST_VAL_SQ       = 3'd5,
        ST_VAL_UNQ      = 3'd6,
        ST_STOPPED      = 3'd7
    } parse_state_t;

    typedef enum logic [1:0] {
        ROLE_NONE  = 2'd0,
        ROLE_NAME  = 2'd1,
        ROLE_VALUE = 2'd2
    } role_t;

    localparam logic [7:0] CH_EQUALS    = 8'h3d;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_CR        = 8'h0d;
    localparam logic [7:0] CH_LF        = 8'h0a;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_VT        = 8'h0b;
    localparam logic [7:0] CH_FF        = 8'h0c;
    localparam logic [7:0] SEP_DEFAULT  = 8'h3b;

    typedef struct packed {
        logic [7:0] out_byte;
        role_t      role;
        logic       pair_done;
    } kvpt_result_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                   (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

`default_nettype wire

>>> src/key_value_param_tokenizer_top.sv
// key_value_param_tokenizer_top: byte-stream tokenizer for name=value lists
// depends on kvpt_pkg and kvpt_core
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+----------------------------
//   in       | sink      | in_valid/in_ready   | in_byte[7:0], last_byte
//   out      | source    | out_valid/out_ready | out_byte[7:0], role[1:0], pair_done
//   cfg      | sink      | cfg_wr_en           | cfg_wr_data[7:0] (separator)
//
// one beat in, one beat out; each result is registered in the result register, or in
// the skid entry while it is held; the parse step is combinational logic between the
// state and result registers, so one byte can be taken per cycle while in_ready is high
// a two-entry output buffer (result register plus skid) keeps in_ready high while one
// result waits; in_ready drops only when both entries are full
// reset: parse state to before-name, separator to ';', output buffer empty
`timescale 1ns / 1ps
`default_nettype none

module key_value_param_tokenizer_top
    import kvpt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic [1:0]       role,
    output logic             pair_done
);

    logic [7:0]   separator_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    kvpt_result_t step_result;

    kvpt_result_t main_reg;
    logic         main_valid_reg;
    kvpt_result_t skid_reg;
    logic         skid_valid_reg;

    logic in_beat;
    logic out_beat;

    assign in_ready = !skid_valid_reg;
    assign in_beat  = in_valid && in_ready;
    assign out_beat = main_valid_reg && out_ready;

    kvpt_core u_core (
        .in_byte    (in_byte),
        .last_byte  (last_byte),
        .separator  (separator_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            separator_reg <= SEP_DEFAULT;
        else if (cfg_wr_en)
            separator_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_BEFORE_NAME;
        else if (in_beat)
            state_reg <= state_next;
    end

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!main_valid_reg || out_ready)
            begin
                main_valid_reg <= skid_valid_reg || in_beat;
                skid_valid_reg <= 1'b0;
            end
            else if (in_beat)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (in_beat)
                main_reg <= step_result;
        end
        else if (in_beat)
        begin
            skid_reg <= step_result;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_byte  = main_reg.out_byte;
    assign role      = main_reg.role;
    assign pair_done = main_reg.pair_done;

    // skid entry only fills behind a held result
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid without result entry");

    // a waiting skid entry moves up when the result is taken
    a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid entry lost on output beat");

    // end of string returns the parser to the start
    a_last_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && last_byte) |=> (state_reg == ST_BEFORE_NAME))
        else $error("parser not at start after final byte");

    // stopped state holds until the final byte
    a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && !last_byte && state_reg == ST_STOPPED) |=> (state_reg == ST_STOPPED))
        else $error("parser left stopped state early");

    // an accepted beat always produces a result
    a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> main_valid_reg)
        else $error("accepted beat produced no result");

endmodule

`default_nettype wire

>>> src/kvpt_core.sv
// kvpt_core: combinational parse step, one byte against the current parse state
// depends on kvpt_pkg
`timescale 1ns / 1ps
`default_nettype none

module kvpt_core
    import kvpt_pkg::*;
(
    input  wire logic [7:0]   in_byte,
    input  wire logic         last_byte,
    input  wire logic [7:0]   separator,
    input  wire parse_state_t state,
    output parse_state_t      state_next,
    output kvpt_result_t      result
);

    logic is_sep;
    logic is_eol;
    logic is_ws;
    logic close_quote;

    assign is_sep = (in_byte == separator);
    assign is_eol = (in_byte == CH_CR) || (in_byte == CH_LF);
    assign is_ws  = is_space(in_byte);
    assign close_quote = ((state == ST_VAL_DQ) && (in_byte == CH_DQUOTE)) ||
                         ((state == ST_VAL_SQ) && (in_byte == CH_SQUOTE));

    // state reached by this byte before the end-of-string flush
    parse_state_t step_state;

    always_comb
    begin
        step_state = state;
        if (state == ST_STOPPED)
        begin
            step_state = ST_STOPPED;
        end
        else if (is_eol)
        begin
            step_state = ST_STOPPED;
        end
        else
        begin
            unique case (state)
                ST_BEFORE_NAME:
                begin
                    if (!is_sep && !is_ws)
                        step_state = ST_IN_NAME;
                end
                ST_IN_NAME:
                begin
                    priority if (!is_ws && in_byte != CH_EQUALS && !is_sep)
                        step_state = ST_IN_NAME;
                    else if (in_byte == CH_EQUALS)
                        step_state = ST_BEFORE_VALUE;
                    else if (is_sep)
                        step_state = ST_BEFORE_NAME;
                    else
                        step_state = ST_AFTER_NAME;
                end
                ST_AFTER_NAME:
                begin
                    if (in_byte == CH_EQUALS)
                        step_state = ST_BEFORE_VALUE;
                end
                ST_BEFORE_VALUE:
                begin
                    if (!is_ws)
                    begin
                        priority if (in_byte == CH_DQUOTE)
                            step_state = ST_VAL_DQ;
                        else if (in_byte == CH_SQUOTE)
                            step_state = ST_VAL_SQ;
                        else
                            step_state = ST_VAL_UNQ;
                    end
                end
                ST_VAL_DQ, ST_VAL_SQ, ST_VAL_UNQ:
                begin
                    if (is_sep || close_quote)
                        step_state = ST_BEFORE_NAME;
                end
                default:
                begin
                    step_state = ST_STOPPED;
                end
            endcase
        end
    end

    // next state: end of string always returns to the start
    always_comb
    begin
        if (last_byte)
            state_next = ST_BEFORE_NAME;
        else
            state_next = step_state;
    end

    // outputs
    always_comb
    begin
        result.out_byte  = in_byte;
        result.role      = ROLE_NONE;
        result.pair_done = 1'b0;
        if (state == ST_STOPPED)
        begin
            result.role = ROLE_NONE;
        end
        else if (is_eol)
        begin
            result.pair_done = (state != ST_BEFORE_NAME);
        end
        else
        begin
            unique case (state)
                ST_BEFORE_NAME:
                begin
                    if (!is_sep && !is_ws)
                        result.role = ROLE_NAME;
                end
                ST_IN_NAME:
                begin
                    priority if (!is_ws && in_byte != CH_EQUALS && !is_sep)
                        result.role = ROLE_NAME;
                    else if (in_byte == CH_EQUALS)
                        result.pair_done = 1'b0;
                    else if (is_sep)
                        result.pair_done = 1'b1;
                    else
                        result.pair_done = 1'b0;
                end
                ST_AFTER_NAME:
                begin
                    result.role = ROLE_NONE;
                end
                ST_BEFORE_VALUE:
                begin
                    if (!is_ws && in_byte != CH_DQUOTE && in_byte != CH_SQUOTE)
                        result.role = ROLE_VALUE;
                end
                ST_VAL_DQ, ST_VAL_SQ, ST_VAL_UNQ:
                begin
                    if (is_sep || close_quote)
                        result.pair_done = 1'b1;
                    else
                        result.role = ROLE_VALUE;
                end
                default:
                begin
                    result.role = ROLE_NONE;
                end
            endcase
        end
        // flush a pending pair at the end of the string
        if (last_byte && step_state != ST_STOPPED && step_state != ST_BEFORE_NAME)
            result.pair_done = 1'b1;
    end

endmodule

`default_nettype wire

>>> tb/tb.sv
// tb: self-checking testbench for key_value_param_tokenizer_top
// depends on kvpt_pkg (state/role enums, character codes, result struct) and the top module
// directed table first, then random name=value lists and noise bytes under several separators
`timescale 1ns / 1ps

module tb;
    import kvpt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 90;
    localparam int N_PHASES = 8;
    localparam int N_DIRECTED = 27;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       typed;
        role_t      role;
        logic       done;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] role;
    logic       pair_done;

    parse_state_t tok_state = ST_BEFORE_NAME;
    logic [7:0]   sep_val = SEP_DEFAULT;
    kvpt_result_t pending_tokens[$];
    logic [7:0]   str_q[$];
    logic         last_q[$];
    bit           failed = 1'b0;
    bit           quiet = 1'b0;
    int           stall_left = 0;
    int           cycle_count = 0;

    logic [7:0] sep_plan [N_PHASES] = '{8'h00, 8'hff, 8'h2c, 8'h3d, 8'h27, 8'h20, 8'h0a, 8'h26};

    // expectations typed in where they read off directly; the rest come from the predictor
    stim_row_t dir_rows [N_DIRECTED] = '{
        '{8'h61, 1'b0, 1'b1, ROLE_NAME,  1'b0},   // first byte after reset starts a name
        '{8'h20, 1'b0, 1'b0, ROLE_NONE,  1'b0},
        '{8'h78, 1'b0, 1'b0, ROLE_NONE,  1'b0},   // stray char after name is dropped
        '{8'h3d, 1'b0, 1'b0, ROLE_NONE,  1'b0},
        '{8'h09, 1'b0, 1'b0, ROLE_NONE,  1'b0},
        '{8'h22, 1'b0, 1'b0, ROLE_NONE,  1'b0},
        '{8'h27, 1'b0, 1'b0, ROLE_NONE,  1'b0},   // other quote kept inside value
        '{8'h3b, 1'b0, 1'b0, ROLE_NONE,  1'b0},   // separator wins over missing close quote
        '{8'h6b, 1'b0, 1'b0, ROLE_NONE,  1'b0},
        '{8'h3d, 1'b0, 1'b0, ROLE_NONE,  1'b0},
        '{8'h3b, 1'b0, 1'b0, ROLE_NONE,  1'b0},   // separator right after '=' is a value char
        '{8'h00, 1'b0, 1'b1, ROLE_VALUE, 1'b0},
        '{8'hff, 1'b0, 1'b1, ROLE_VALUE, 1'b0},
        '{8'h0d, 1'b0, 1'b1, ROLE_NONE,  1'b1},
        '{8'h7a, 1'b0, 1'b0, ROLE_NONE,  1'b0},
        '{8'h71, 1'b1, 1'b0, ROLE_NONE,  1'b0},   // final byte leaves the stopped state
        '{8'hff, 1'b0, 1'b1, ROLE_NAME,  1'b0},
        '{8'h3d, 1'b0, 1'b0, ROLE_NONE,  1'b0},
        '{8'h27, 1'b0, 1'b0, ROLE_NONE,  1'b0},
        '{8'h22, 1'b0, 1'b0, ROLE_NONE,  1'b0},
        '{8'h27, 1'b0, 1'b0, ROLE_NONE,  1'b0},
        '{8'h0a, 1'b0, 1'b0, ROLE_NONE,  1'b0},   // LF with no name pending
        '{8'h00, 1'b1, 1'b1, ROLE_NONE,  1'b0},
        '{8'h6e, 1'b1, 1'b1, ROLE_NAME,  1'b1},   // one-byte string closes its own pair
        '{8'h20, 1'b1, 1'b0, ROLE_NONE,  1'b0},
        '{8'h76, 1'b0, 1'b0, ROLE_NONE,  1'b0},
        '{8'h3b, 1'b0, 1'b0, ROLE_NONE,  1'b0}
    };

    key_value_param_tokenizer_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .role        (role),
        .pair_done   (pair_done)
    );

    always #5 clk = ~clk;

    // next token tag for one byte; advances the tracked parse state
    function automatic kvpt_result_t predict_token(input logic [7:0] b, input logic last);
        kvpt_result_t r;
        logic         blank;
        parse_state_t nxt;
        blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
                (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
        r.out_byte = b;
        r.role = ROLE_NONE;
        r.pair_done = 1'b0;
        nxt = tok_state;
        if (tok_state == ST_STOPPED)
        begin
            nxt = ST_STOPPED;
        end
        else if (b == CH_CR || b == CH_LF)
        begin
            r.pair_done = (tok_state != ST_BEFORE_NAME);
            nxt = ST_STOPPED;
        end
        else
        begin
            case (tok_state)
                ST_BEFORE_NAME:
                begin
                    if (b != sep_val && !blank)
                    begin
                        r.role = ROLE_NAME;
                        nxt = ST_IN_NAME;
                    end
                end
                ST_IN_NAME:
                begin
                    if (!blank && b != CH_EQUALS && b != sep_val)
                        r.role = ROLE_NAME;
                    else if (b == CH_EQUALS)
                        nxt = ST_BEFORE_VALUE;
                    else if (b == sep_val)
                    begin
                        r.pair_done = 1'b1;
                        nxt = ST_BEFORE_NAME;
                    end
                    else
                        nxt = ST_AFTER_NAME;
                end
                ST_AFTER_NAME:
                begin
                    if (b == CH_EQUALS)
                        nxt = ST_BEFORE_VALUE;
                end
                ST_BEFORE_VALUE:
                begin
                    if (!blank)
                    begin
                        if (b == CH_DQUOTE)
                            nxt = ST_VAL_DQ;
                        else if (b == CH_SQUOTE)
                            nxt = ST_VAL_SQ;
                        else
                        begin
                            r.role = ROLE_VALUE;
                            nxt = ST_VAL_UNQ;
                        end
                    end
                end
                default:
                begin
                    // separator is tested ahead of the closing quote
                    if (b == sep_val ||
                        (tok_state == ST_VAL_DQ && b == CH_DQUOTE) ||
                        (tok_state == ST_VAL_SQ && b == CH_SQUOTE))
                    begin
                        r.pair_done = 1'b1;
                        nxt = ST_BEFORE_NAME;
                    end
                    else
                        r.role = ROLE_VALUE;
                end
            endcase
        end
        if (last)
        begin
            if (nxt != ST_STOPPED && nxt != ST_BEFORE_NAME)
                r.pair_done = 1'b1;
            nxt = ST_BEFORE_NAME;
        end
        tok_state = nxt;
        return r;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        while (c == CH_EQUALS || c == sep_val)
            c = 8'($urandom_range(33, 126));
        return c;
    endfunction

    function automatic logic [7:0] value_char(input int quote_kind);
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        c = 8'($urandom_range(32, 126));
        while (c == sep_val || (quote_kind == 1 && c == CH_DQUOTE) ||
               (quote_kind == 2 && c == CH_SQUOTE))
            c = 8'($urandom_range(32, 126));
        return c;
    endfunction

    // one input beat; valid stays up afterwards unless the next call idles
    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input kvpt_result_t typed_res);
        kvpt_result_t r;
        int           gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = predict_token(b, last);
        pending_tokens.push_back(typed ? typed_res : r);
    endtask

    task automatic drain_tokens();
        in_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_separator(input logic [7:0] v);
        drain_tokens();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sep_val = v;
    endtask

    // list of name=value pairs with random content, optionally damaged
    task automatic build_list(input logic corrupt);
        int npairs;
        int quote_kind;
        str_q.delete();
        npairs = $urandom_range(1, 4);
        for (int p = 0; p < npairs; p++)
        begin
            repeat ($urandom_range(0, 2)) str_q.push_back(blank_char());
            repeat ($urandom_range(1, 6)) str_q.push_back(name_char());
            repeat ($urandom_range(0, 1)) str_q.push_back(blank_char());
            str_q.push_back(CH_EQUALS);
            repeat ($urandom_range(0, 1)) str_q.push_back(blank_char());
            quote_kind = $urandom_range(0, 2);
            if (quote_kind == 1)
                str_q.push_back(CH_DQUOTE);
            else if (quote_kind == 2)
                str_q.push_back(CH_SQUOTE);
            repeat ($urandom_range(0, 6)) str_q.push_back(value_char(quote_kind));
            if (quote_kind == 1)
                str_q.push_back(CH_DQUOTE);
            else if (quote_kind == 2)
                str_q.push_back(CH_SQUOTE);
            if (p != npairs - 1 || $urandom_range(0, 1) == 1)
                str_q.push_back(sep_val);
        end
        // line break stops parsing; trailing junk must be ignored
        if ($urandom_range(0, 4) == 0)
        begin
            str_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
            repeat ($urandom_range(0, 3)) str_q.push_back(8'($urandom_range(0, 255)));
        end
        if (corrupt)
        begin
            foreach (str_q[i])
                if ($urandom_range(0, 7) == 0)
                    str_q[i] = 8'($urandom_range(0, 255));
        end
        last_q.delete();
        foreach (str_q[i])
            last_q.push_back(i == str_q.size() - 1);
    endtask

    // input side: reset, directed table, random phases, final drain
    initial
    begin
        kvpt_result_t typed_res;
        int           sent;
        int           pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            typed_res.out_byte = dir_rows[i].b;
            typed_res.role = dir_rows[i].role;
            typed_res.pair_done = dir_rows[i].done;
            send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, typed_res);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_separator(sep_plan[ph]);
            if (ph == N_PHASES - 1)
                quiet = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 9)
                    build_list(pick >= 7);
                else
                begin
                    // pure noise, final flag at random
                    str_q.delete();
                    last_q.delete();
                    repeat ($urandom_range(1, 8))
                    begin
                        str_q.push_back(8'($urandom_range(0, 255)));
                        last_q.push_back($urandom_range(0, 3) == 0);
                    end
                end
                foreach (str_q[i])
                    send_byte(str_q[i], last_q[i], 1'b0, '0);
                sent += str_q.size();
            end
        end

        drain_tokens();
        repeat (8) @(posedge clk);
        if (failed)
            $display("Test completed with failures");
        else
            $display("Test completed successfully");
        $finish;
    end

    // output side backpressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end
        else
            out_ready <= 1'b1;
    end

    // compare every output beat with the oldest expected token
    always @(posedge clk)
    begin
        kvpt_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_tokens.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got byte %h role %0d done %0d",
                         $time, out_byte, role, pair_done);
                failed = 1'b1;
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (out_byte !== want.out_byte)
                begin
                    $display("%0t: out_byte expected %h got %h", $time, want.out_byte, out_byte);
                    failed = 1'b1;
                end
                if (role !== want.role)
                begin
                    $display("%0t: role expected %0d got %0d (byte %h)",
                             $time, want.role, role, want.out_byte);
                    failed = 1'b1;
                end
                if (pair_done !== want.pair_done)
                begin
                    $display("%0t: pair_done expected %0d got %0d (byte %h)",
                             $time, want.pair_done, pair_done, want.out_byte);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d tokens still expected", $time, pending_tokens.size());
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

>>> key_value_param_tokenizer_top.f
src/kvpt_pkg.sv
src/kvpt_core.sv
src/key_value_param_tokenizer_top.sv
tb/tb.sv
